// ----- hdl/iir4_pkg.sv -----
// Shared types, constants and arithmetic helpers of the 4th-order elliptic low-pass filter.
// Used by iir4_rom, iir4_seq, iir4_dp and the top level; depends on nothing else.
package iir4_pkg;

  localparam int ACC_W  = 64;
  localparam int COEF_W = 32;
  localparam int STEP_W = 4;
  localparam int NTAPS  = 4;

  // Fixed entry points of the microprogram.
  localparam logic [STEP_W-1:0] STEP_OUT = 4'd13;
  localparam logic [STEP_W-1:0] STEP_CLR = 4'd14;

  localparam logic signed [ACC_W-1:0] ACC_MAX   = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [ACC_W-1:0] ACC_MIN   = 64'sh8000_0000_0000_0000;
  // Bounds on the upper partial product before it is scaled by 16.
  localparam logic signed [ACC_W-1:0] P_HI_LIM  = 64'sh07FF_FFFF_FFFF_FFFF;
  localparam logic signed [ACC_W-1:0] P_LO_LIM  = 64'shF800_0000_0000_0000;
  localparam logic signed [64:0]      PROD_RND  = 65'sd134217728;
  localparam logic signed [ACC_W-1:0] OUT_RND   = 64'sd32768;

  typedef enum logic [3:0] {
    C_B0 = 4'd0,
    C_B1 = 4'd1,
    C_B2 = 4'd2,
    C_B3 = 4'd3,
    C_B4 = 4'd4,
    C_A1 = 4'd5,
    C_A2 = 4'd6,
    C_A3 = 4'd7,
    C_A4 = 4'd8
  } coef_e;

  typedef enum logic {
    DST_W = 1'b0,   // feedback accumulator, term is subtracted
    DST_Y = 1'b1    // output accumulator, term is added
  } dst_e;

  typedef enum logic [1:0] {
    JMP_NONE   = 2'd0,
    JMP_IF_CLR = 2'd1,
    JMP_ALWAYS = 2'd2
  } jmp_e;

  typedef struct packed {
    logic        mul_en;
    logic [1:0]  tap;
    coef_e       coef;
    dst_e        dst;
    logic        upd_w;
    logic        clr_dl;
  } ctrl_t;

  typedef struct packed {
    ctrl_t             ctrl;
    jmp_e              jmp;
    logic [STEP_W-1:0] target;
    logic              last;
  } ucode_t;

  typedef struct packed {
    logic busy;
    logic done;
  } stat_t;

  // Q3.28 coefficients.
  function automatic logic signed [COEF_W-1:0] coef(input coef_e sel);
    logic signed [COEF_W-1:0] c;
    unique case (sel)
      C_B0, C_B4: c = 32'sd843946;
      C_B1, C_B3: c = -32'sd3370389;
      C_B2:       c = 32'sd5052892;
      C_A1:       c = -32'sd1069689607;
      C_A2:       c = 32'sd1598555035;
      C_A3:       c = -32'sd1061782256;
      C_A4:       c = 32'sd264481378;
      default:    c = '0;
    endcase
    return c;
  endfunction

  function automatic logic signed [ACC_W-1:0] sat_add(input logic signed [ACC_W-1:0] a,
                                                      input logic signed [ACC_W-1:0] b);
    logic signed [ACC_W:0] s;
    s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
    if (s[ACC_W] != s[ACC_W-1]) begin
      return s[ACC_W] ? ACC_MIN : ACC_MAX;
    end
    return s[ACC_W-1:0];
  endfunction

  function automatic logic signed [ACC_W-1:0] sat_sub(input logic signed [ACC_W-1:0] a,
                                                      input logic signed [ACC_W-1:0] b);
    logic signed [ACC_W:0] s;
    s = {a[ACC_W-1], a} - {b[ACC_W-1], b};
    if (s[ACC_W] != s[ACC_W-1]) begin
      return s[ACC_W] ? ACC_MIN : ACC_MAX;
    end
    return s[ACC_W-1:0];
  endfunction

endpackage

// ----- hdl/iir4_rom.sv -----
// Microprogram store of the filter sequencer: one control word per step.
// Depends on iir4_pkg.
module iir4_rom (
  input  logic [iir4_pkg::STEP_W-1:0] step_i,
  output iir4_pkg::ucode_t            word_o
);

  function automatic iir4_pkg::ucode_t mac(input logic [1:0] tap,
                                           input iir4_pkg::coef_e c,
                                           input iir4_pkg::dst_e d);
    iir4_pkg::ucode_t w;
    w             = '0;
    w.ctrl.mul_en = 1'b1;
    w.ctrl.tap    = tap;
    w.ctrl.coef   = c;
    w.ctrl.dst    = d;
    w.jmp         = iir4_pkg::JMP_NONE;
    return w;
  endfunction

  always_comb begin
    word_o = '0;
    unique case (step_i)
      4'd0: begin
        word_o        = mac(2'd3, iir4_pkg::C_A4, iir4_pkg::DST_W);
        word_o.jmp    = iir4_pkg::JMP_IF_CLR;
        word_o.target = iir4_pkg::STEP_CLR;
      end
      4'd1:  word_o = mac(2'd3, iir4_pkg::C_B4, iir4_pkg::DST_Y);
      4'd2:  word_o = mac(2'd2, iir4_pkg::C_A3, iir4_pkg::DST_W);
      4'd3:  word_o = mac(2'd2, iir4_pkg::C_B3, iir4_pkg::DST_Y);
      4'd4:  word_o = mac(2'd1, iir4_pkg::C_A2, iir4_pkg::DST_W);
      4'd5:  word_o = mac(2'd1, iir4_pkg::C_B2, iir4_pkg::DST_Y);
      4'd6:  word_o = mac(2'd0, iir4_pkg::C_A1, iir4_pkg::DST_W);
      4'd7:  word_o = mac(2'd0, iir4_pkg::C_B1, iir4_pkg::DST_Y);
      // The last feedback term lands in the accumulator during step 8.
      4'd9:  word_o.ctrl.upd_w = 1'b1;
      // The new w now sits in tap 0.
      4'd10: word_o = mac(2'd0, iir4_pkg::C_B0, iir4_pkg::DST_Y);
      4'd13: word_o.last = 1'b1;
      4'd14: begin
        word_o.ctrl.clr_dl = 1'b1;
        word_o.jmp         = iir4_pkg::JMP_ALWAYS;
        word_o.target      = iir4_pkg::STEP_OUT;
      end
      4'd15: word_o.last = 1'b1;
      default: word_o.jmp = iir4_pkg::JMP_NONE;
    endcase
  end

endmodule

// ----- hdl/iir4_seq.sv -----
// Step counter and jump logic of the filter sequencer.
// Depends on iir4_pkg and iir4_rom.
module iir4_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                op_i,
  input  logic                out_free_i,
  output iir4_pkg::ctrl_t     ctrl_o,
  output iir4_pkg::stat_t     stat_o
);

  typedef enum logic [1:0] {
    SEQ_IDLE = 2'b01,
    SEQ_RUN  = 2'b10
  } seq_state_e;

  seq_state_e                  state_q, state_d;
  logic [iir4_pkg::STEP_W-1:0] step_q, step_d;
  logic                        op_q, op_d;
  logic                        done;
  iir4_pkg::ucode_t            word;

  iir4_rom u_rom (
    .step_i (step_q),
    .word_o (word)
  );

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    op_d    = op_q;
    ctrl_o  = '0;
    done    = 1'b0;
    unique case (state_q)
      SEQ_IDLE: begin
        if (start_i) begin
          state_d = SEQ_RUN;
          step_d  = '0;
          op_d    = op_i;
        end
      end
      SEQ_RUN: begin
        ctrl_o = word.ctrl;
        if (word.last) begin
          // Hold on the final step until the output register can take the result.
          if (out_free_i) begin
            done    = 1'b1;
            state_d = SEQ_IDLE;
          end
        end else begin
          case (word.jmp)
            iir4_pkg::JMP_ALWAYS: step_d = word.target;
            iir4_pkg::JMP_IF_CLR: begin
              if (op_q) begin
                step_d        = word.target;
                ctrl_o.mul_en = 1'b0;
              end else begin
                step_d = step_q + iir4_pkg::STEP_W'(1);
              end
            end
            default: step_d = step_q + iir4_pkg::STEP_W'(1);
          endcase
        end
      end
      default: state_d = SEQ_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SEQ_IDLE;
      step_q  <= '0;
      op_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      op_q    <= op_d;
    end
  end

  assign stat_o.busy = (state_q != SEQ_IDLE);
  assign stat_o.done = done;

endmodule

// ----- hdl/iir4_dp.sv -----
// Datapath of the filter: delay line, shared two-part multiplier, product rounding,
// the two saturating accumulators and output rounding. Depends on iir4_pkg.
module iir4_dp #(
  parameter int DATA_WIDTH  = 32,
  parameter int STATE_WIDTH = 48
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         load_i,
  input  logic signed [DATA_WIDTH-1:0] sample_i,
  input  iir4_pkg::ctrl_t              ctrl_i,
  output logic        [DATA_WIDTH-1:0] y_o
);

  localparam int AW = iir4_pkg::ACC_W;
  localparam logic signed [AW-1:0] W_MAX = (64'sd1 <<< (STATE_WIDTH - 1)) - 64'sd1;
  localparam logic signed [AW-1:0] W_MIN = -W_MAX - 64'sd1;
  localparam logic signed [AW-1:0] Y_MAX = (64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1;
  localparam logic signed [AW-1:0] Y_MIN = -Y_MAX - 64'sd1;

  logic signed [STATE_WIDTH-1:0]    dl_q [iir4_pkg::NTAPS];
  logic signed [STATE_WIDTH-1:0]    opnd;
  logic signed [STATE_WIDTH-33:0]   opnd_hi;
  logic signed [iir4_pkg::COEF_W-1:0] c;
  logic signed [STATE_WIDTH-1:0]    p_hi_d, p_hi_q;
  logic signed [64:0]               p_lo_d, p_lo_q, lo_rnd;
  logic                             mv_q, tv_q;
  iir4_pkg::dst_e                   mdst_q, tdst_q;
  logic signed [AW-1:0]             p_hi_x, hi_part, lo_part, term_d, term_q;
  logic signed [AW-1:0]             acc_q, yacc_q, w_sat, y_rnd, y_shr, y_sat;

  // Stage 1: operand high half (signed) and low half (unsigned) times the coefficient.
  assign opnd    = dl_q[ctrl_i.tap];
  assign opnd_hi = opnd[STATE_WIDTH-1:32];
  assign c       = iir4_pkg::coef(ctrl_i.coef);
  assign p_hi_d  = opnd_hi * c;
  assign p_lo_d  = $signed({1'b0, opnd[31:0]}) * c;

  always_ff @(posedge clk_i) begin
    p_hi_q <= p_hi_d;
    p_lo_q <= p_lo_d;
  end

  // Stage 2: scale the high part by 16 with clamping, round the low part from Q.60.
  assign p_hi_x  = AW'(p_hi_q);
  assign hi_part = (p_hi_x > iir4_pkg::P_HI_LIM) ? iir4_pkg::ACC_MAX :
                   (p_hi_x < iir4_pkg::P_LO_LIM) ? iir4_pkg::ACC_MIN : (p_hi_x <<< 4);
  assign lo_rnd  = p_lo_q + iir4_pkg::PROD_RND;
  assign lo_part = AW'(lo_rnd >>> 28);
  assign term_d  = iir4_pkg::sat_add(hi_part, lo_part);

  always_ff @(posedge clk_i) begin
    term_q <= term_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mv_q   <= 1'b0;
      tv_q   <= 1'b0;
      mdst_q <= iir4_pkg::DST_W;
      tdst_q <= iir4_pkg::DST_W;
    end else begin
      mv_q   <= ctrl_i.mul_en;
      mdst_q <= ctrl_i.dst;
      tv_q   <= mv_q;
      tdst_q <= mdst_q;
    end
  end

  // Stage 3: accumulate.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      acc_q  <= AW'(sample_i) <<< 16;
      yacc_q <= '0;
    end else if (tv_q) begin
      if (tdst_q == iir4_pkg::DST_W) begin
        acc_q <= iir4_pkg::sat_sub(acc_q, term_q);
      end else begin
        yacc_q <= iir4_pkg::sat_add(yacc_q, term_q);
      end
    end
  end

  // New w, saturated to the state width, is shifted in at the head of the delay line.
  assign w_sat = (acc_q > W_MAX) ? W_MAX : (acc_q < W_MIN) ? W_MIN : acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < iir4_pkg::NTAPS; k++) begin
        dl_q[k] <= '0;
      end
    end else if (ctrl_i.clr_dl) begin
      for (int k = 0; k < iir4_pkg::NTAPS; k++) begin
        dl_q[k] <= '0;
      end
    end else if (ctrl_i.upd_w) begin
      for (int k = iir4_pkg::NTAPS - 1; k > 0; k--) begin
        dl_q[k] <= dl_q[k-1];
      end
      dl_q[0] <= w_sat[STATE_WIDTH-1:0];
    end
  end

  // Q.32 to Q.16 with round half up, then saturate to the sample width.
  assign y_rnd = iir4_pkg::sat_add(yacc_q, iir4_pkg::OUT_RND);
  assign y_shr = y_rnd >>> 16;
  assign y_sat = (y_shr > Y_MAX) ? Y_MAX : (y_shr < Y_MIN) ? Y_MIN : y_shr;
  assign y_o   = y_sat[DATA_WIDTH-1:0];

endmodule

// ----- hdl/elliptic_iir_lowpass_order4_top.sv -----
// A filter transfer hands on its result once its microprogram has run; a clear does too.
// A new transfer is taken only after the previous one has finished; the nine coefficient
// products share one multiply unit issued by a 14-step microprogram.
// The result register frees the input side as soon as a result is handed to it.
// Reset (rst_ni low, asynchronous) zeroes the delay line and empties the result register.
module elliptic_iir_lowpass_order4_top #(
  parameter int DATA_WIDTH  = 32,
  parameter int STATE_WIDTH = 48
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // tdata: sample (DATA_WIDTH bits, signed), zero padded to whole bytes.
  input  logic [((DATA_WIDTH+7)/8)*8-1:0]     s_axis_tdata_i,
  // tuser: op (bit 0; 0 filters the sample, 1 clears the delay line).
  input  logic [0:0]                          s_axis_tuser_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // tdata: filtered (DATA_WIDTH bits, signed), zero padded to whole bytes.
  output logic [((DATA_WIDTH+7)/8)*8-1:0]     m_axis_tdata_o
);

  localparam int TDATA_W = ((DATA_WIDTH + 7) / 8) * 8;

  logic                  s_accept;
  logic                  out_free;
  iir4_pkg::ctrl_t       ctrl;
  iir4_pkg::stat_t       stat;
  logic [DATA_WIDTH-1:0] y;
  logic                  m_valid_q;
  logic [DATA_WIDTH-1:0] m_data_q;

  // The sequencer takes a new transfer only when it is idle.
  assign s_axis_tready_o = !stat.busy;
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;

  // The result register can be loaded when empty or being drained in this cycle.
  assign out_free = !m_valid_q || m_axis_tready_i;

  iir4_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (s_accept),
    .op_i       (s_axis_tuser_i[0]),
    .out_free_i (out_free),
    .ctrl_o     (ctrl),
    .stat_o     (stat)
  );

  iir4_dp #(
    .DATA_WIDTH  (DATA_WIDTH),
    .STATE_WIDTH (STATE_WIDTH)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (s_accept),
    .sample_i ($signed(s_axis_tdata_i[DATA_WIDTH-1:0])),
    .ctrl_i   (ctrl),
    .y_o      (y)
  );

  // Result register: loaded when the microprogram finishes, cleared when taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (stat.done) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stat.done) begin
      m_data_q <= y;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = TDATA_W'(m_data_q);

  // Once a transfer is accepted the input side stays closed for at least the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept |=> !s_axis_tready_o)
    else $error("input accepted again right after a transfer");

  // A finished result never overwrites one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.done |-> (!m_valid_q || m_axis_tready_i))
    else $error("result register overwritten");

  // A finished result is presented in the next cycle.
  a_done_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.done |=> m_axis_tvalid_o)
    else $error("finished result not presented");

  // The sequencer never finishes while idle.
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.done |-> stat.busy)
    else $error("completion signaled while idle");

endmodule
